>>> rtl/slt_pkg.sv
// Shared types, constants and sizes for the script lexer token splitter.
// Used by slt_lex_decode, slt_text_ram and script_lexer_token_splitter.
// Depends on nothing.
package slt_pkg;

    localparam int TOK_MAX   = 16;
    localparam int LINE_BITS = 16;
    localparam int ADDR_W    = $clog2(TOK_MAX);
    localparam int LEN_W     = $clog2(TOK_MAX + 1);

    localparam logic [LEN_W-1:0]     TOK_MAX_LEN = LEN_W'(TOK_MAX);
    localparam logic [LINE_BITS-1:0] LINE_MAX    = '1;
    localparam logic [LINE_BITS-1:0] LINE_FIRST  = LINE_BITS'(1);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] KIND_OP  = 3'd0;
    localparam logic [2:0] KIND_ERR = 3'd6;
    localparam logic [2:0] KIND_END = 3'd7;

    typedef enum logic [2:0] {
        M_WS      = 3'd0,
        M_IDENT   = 3'd1,
        M_INT     = 3'd2,
        M_DEC     = 3'd3,
        M_STR     = 3'd4,
        M_SLASH   = 3'd5,
        M_COMMENT = 3'd6,
        M_PDOT    = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_FIN
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_A,
        ST_AFTER_A,
        ST_START_B,
        ST_DECODE,
        ST_FL_RD,
        ST_FL_EMIT,
        ST_FL_EMPTY,
        ST_POST,
        ST_OP1,
        ST_OP2,
        ST_ERR,
        ST_FIN,
        ST_END
    } state_t;

    typedef struct packed {
        logic       finish;
        logic       set_mode;
        mode_t      new_mode;
        logic       append;
        logic [1:0] op_cnt;
        logic [7:0] op_a;
        logic [7:0] op_b;
        logic       err;
        logic       line_inc;
        logic       cmt_clear;
        logic       used;
    } lex_action_t;

endpackage

>>> rtl/slt_text_ram.sv
// Token text buffer: one write port, one read port with registered read data.
// Depends on slt_pkg for depth and address width.
module slt_text_ram
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [slt_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic                      rd_en,
    input  logic [slt_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                rd_data
);

    logic [7:0] mem [slt_pkg::TOK_MAX];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/slt_lex_decode.sv
// Character classifier: decides what one source byte does to the lexer state.
// Depends on slt_pkg for the mode and action types.
module slt_lex_decode
(
    input  logic [7:0]          cur_byte,
    input  slt_pkg::mode_t      mode,
    input  logic [7:0]          la_byte,
    input  logic                la_ok,
    output slt_pkg::lex_action_t act
);

    logic str;
    logic digit;
    logic la_eq;
    logic la_same;

    always_comb
    begin
        str     = (mode == slt_pkg::M_STR);
        digit   = (cur_byte >= slt_pkg::CH_ZERO) && (cur_byte <= slt_pkg::CH_NINE);
        la_eq   = la_ok && (la_byte == slt_pkg::CH_EQ);
        la_same = la_ok && (la_byte == cur_byte);
        act           = '0;
        act.new_mode  = slt_pkg::M_WS;
        act.op_a      = cur_byte;
        act.op_b      = la_byte;
        if (mode == slt_pkg::M_COMMENT && cur_byte != slt_pkg::CH_CR
            && cur_byte != slt_pkg::CH_LF)
        begin
            act.finish = 1'b0;
        end
        else if (digit)
        begin
            act.append = 1'b1;
            if (mode == slt_pkg::M_WS)
            begin
                act.set_mode = 1'b1;
                act.new_mode = slt_pkg::M_INT;
            end
            else if (mode == slt_pkg::M_PDOT)
            begin
                act.set_mode = 1'b1;
                act.new_mode = slt_pkg::M_DEC;
            end
        end
        else
        begin
            unique case (cur_byte)
                slt_pkg::CH_EQ, slt_pkg::CH_PLUS, slt_pkg::CH_STAR, slt_pkg::CH_MINUS:
                begin
                    if (str)
                    begin
                        act.append = 1'b1;
                    end
                    else
                    begin
                        act.finish = 1'b1;
                        act.op_cnt = la_eq ? 2'd2 : 2'd1;
                        act.used   = la_eq;
                    end
                end
                slt_pkg::CH_GT, slt_pkg::CH_LT, slt_pkg::CH_LBRC, slt_pkg::CH_RBRC,
                slt_pkg::CH_LPAR, slt_pkg::CH_RPAR, slt_pkg::CH_SEMI, slt_pkg::CH_LBRK,
                slt_pkg::CH_RBRK, slt_pkg::CH_PCT, slt_pkg::CH_COMMA:
                begin
                    if (str)
                    begin
                        act.append = 1'b1;
                    end
                    else
                    begin
                        act.finish = 1'b1;
                        act.op_cnt = 2'd1;
                    end
                end
                slt_pkg::CH_AMP, slt_pkg::CH_BAR:
                begin
                    if (str)
                    begin
                        act.append = 1'b1;
                    end
                    else
                    begin
                        act.finish = 1'b1;
                        act.op_cnt = la_same ? 2'd2 : 2'd0;
                        act.err    = !la_same;
                        act.used   = la_same;
                    end
                end
                slt_pkg::CH_DOT:
                begin
                    if (mode == slt_pkg::M_WS)
                    begin
                        act.set_mode = 1'b1;
                        act.new_mode = slt_pkg::M_PDOT;
                        act.append   = 1'b1;
                    end
                    else if (mode == slt_pkg::M_INT)
                    begin
                        act.set_mode = 1'b1;
                        act.new_mode = slt_pkg::M_DEC;
                        act.append   = 1'b1;
                    end
                    else if (str)
                    begin
                        act.append = 1'b1;
                    end
                    else
                    begin
                        act.finish = 1'b1;
                        act.op_cnt = 2'd1;
                    end
                end
                slt_pkg::CH_QUOTE:
                begin
                    act.finish   = 1'b1;
                    act.set_mode = !str;
                    act.new_mode = slt_pkg::M_STR;
                end
                slt_pkg::CH_SPACE:
                begin
                    act.append = str;
                    act.finish = !str;
                end
                slt_pkg::CH_TAB:
                begin
                    act.finish = 1'b0;
                end
                slt_pkg::CH_CR, slt_pkg::CH_LF:
                begin
                    act.finish   = 1'b1;
                    act.line_inc = 1'b1;
                end
                slt_pkg::CH_SLASH:
                begin
                    if (str)
                    begin
                        act.append = 1'b1;
                    end
                    else if (mode == slt_pkg::M_SLASH)
                    begin
                        act.set_mode  = 1'b1;
                        act.new_mode  = slt_pkg::M_COMMENT;
                        act.cmt_clear = 1'b1;
                    end
                    else
                    begin
                        act.finish   = 1'b1;
                        act.set_mode = 1'b1;
                        act.new_mode = slt_pkg::M_SLASH;
                        act.append   = 1'b1;
                    end
                end
                default:
                begin
                    act.append = 1'b1;
                    if (mode == slt_pkg::M_WS || mode == slt_pkg::M_INT
                        || mode == slt_pkg::M_DEC || mode == slt_pkg::M_PDOT)
                    begin
                        act.finish   = 1'b1;
                        act.set_mode = 1'b1;
                        act.new_mode = slt_pkg::M_IDENT;
                    end
                end
            endcase
        end
    end

endmodule

>>> rtl/script_lexer_token_splitter.sv
// A token end emits one record per buffered byte, or a single record for an empty token, and
// one per operator byte or error. The last byte of a text is followed by the end record.
// Throughput: one byte at a time; each record waits in the output register while m_tready is low.
// Reset: rst_n is asynchronous and active low; it clears control state and sets the line to one.
// The text memory is not cleared; only entries written for the current token are read.
module script_lexer_token_splitter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] char_out, [8] char_valid, [24:9] line_count,
                                   // [25] was_truncated, [31:26] zero
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // token_done
);

    slt_pkg::state_t      state_reg, state_next;
    slt_pkg::phase_t      phase_reg, phase_next;
    slt_pkg::mode_t       mode_reg, mode_next;
    slt_pkg::lex_action_t act_reg, act_next, act;

    logic [7:0]                  in_byte_reg, in_byte_next;
    logic                        last_reg, last_next;
    logic [7:0]                  held_reg, held_next;
    logic                        held_valid_reg, held_valid_next;
    logic                        skip_reg, skip_next;
    logic                        used_reg, used_next;
    logic                        a_live_reg, a_live_next;
    logic [7:0]                  cur_reg, cur_next;
    logic                        la_ok_reg, la_ok_next;
    logic [slt_pkg::LEN_W-1:0]   len_reg, len_next;
    logic                        ovf_reg, ovf_next;
    logic [slt_pkg::LINE_BITS-1:0] line_reg, line_next;
    logic                        drain_reg, drain_next;
    logic [slt_pkg::ADDR_W-1:0]  idx_reg, idx_next;

    logic                        out_valid_reg;
    logic [2:0]                  out_kind_reg;
    logic [7:0]                  out_char_reg;
    logic                        out_cv_reg;
    logic [15:0]                 out_line_reg;
    logic                        out_done_reg;
    logic                        out_trunc_reg;

    logic                        out_free;
    logic                        emit;
    logic [2:0]                  e_kind;
    logic [7:0]                  e_char;
    logic                        e_cv;
    logic                        e_done;
    logic                        e_trunc;
    logic [15:0]                 line_out;
    logic [slt_pkg::LINE_BITS+15:0] line_wide;

    logic                        wr_en;
    logic [slt_pkg::ADDR_W-1:0]  wr_addr;
    logic                        rd_en;
    logic [7:0]                  rd_data;

    logic                        mode_emits;
    logic                        flush_last;
    slt_pkg::state_t             lex_ret;
    slt_pkg::state_t             flush_ret;

    slt_lex_decode u_decode
    (
        .cur_byte (cur_reg),
        .mode     (mode_reg),
        .la_byte  (in_byte_reg),
        .la_ok    (la_ok_reg),
        .act      (act)
    );

    slt_text_ram u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cur_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_free   = !out_valid_reg || m_tready;
        mode_emits = (mode_reg != slt_pkg::M_WS) && (mode_reg != slt_pkg::M_COMMENT);
        flush_last = ((slt_pkg::LEN_W'(idx_reg) + slt_pkg::LEN_W'(1)) == len_reg);
        lex_ret    = (phase_reg == slt_pkg::PH_A) ? slt_pkg::ST_AFTER_A : slt_pkg::ST_FIN;
        flush_ret  = (phase_reg == slt_pkg::PH_FIN) ? slt_pkg::ST_END : slt_pkg::ST_POST;
        line_wide  = (slt_pkg::LINE_BITS + 16)'(line_reg);
        line_out   = (line_wide > (slt_pkg::LINE_BITS + 16)'(16'hFFFF)) ? 16'hFFFF
                                                                        : line_wide[15:0];
    end

    // Output and memory control.
    always_comb
    begin
        emit    = 1'b0;
        e_kind  = slt_pkg::KIND_OP;
        e_char  = 8'h00;
        e_cv    = 1'b0;
        e_done  = 1'b0;
        e_trunc = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = len_reg[slt_pkg::ADDR_W-1:0];
        s_tready = (state_reg == slt_pkg::ST_IDLE);
        unique case (state_reg)
            slt_pkg::ST_FL_RD:
            begin
                rd_en = (len_reg != '0);
            end
            slt_pkg::ST_FL_EMIT, slt_pkg::ST_FL_EMPTY:
            begin
                emit    = 1'b1;
                e_kind  = (mode_reg == slt_pkg::M_PDOT) ? slt_pkg::KIND_OP : 3'(mode_reg);
                e_trunc = ovf_reg;
                e_cv    = (state_reg == slt_pkg::ST_FL_EMIT);
                e_char  = (state_reg == slt_pkg::ST_FL_EMIT) ? rd_data : 8'h00;
                e_done  = (state_reg == slt_pkg::ST_FL_EMPTY) || flush_last;
            end
            slt_pkg::ST_POST:
            begin
                wr_en = act_reg.append && (len_reg < slt_pkg::TOK_MAX_LEN);
            end
            slt_pkg::ST_OP1:
            begin
                emit   = 1'b1;
                e_char = act_reg.op_a;
                e_cv   = 1'b1;
                e_done = (act_reg.op_cnt == 2'd1);
            end
            slt_pkg::ST_OP2:
            begin
                emit   = 1'b1;
                e_char = act_reg.op_b;
                e_cv   = 1'b1;
                e_done = 1'b1;
            end
            slt_pkg::ST_ERR:
            begin
                emit   = 1'b1;
                e_kind = slt_pkg::KIND_ERR;
                e_char = act_reg.op_a;
                e_cv   = 1'b1;
                e_done = 1'b1;
            end
            slt_pkg::ST_END:
            begin
                emit   = 1'b1;
                e_kind = slt_pkg::KIND_END;
                e_done = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Next state and register updates.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        mode_next       = mode_reg;
        act_next        = act_reg;
        in_byte_next    = in_byte_reg;
        last_next       = last_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        skip_next       = skip_reg;
        used_next       = used_reg;
        a_live_next     = a_live_reg;
        cur_next        = cur_reg;
        la_ok_next      = la_ok_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        line_next       = line_reg;
        drain_next      = drain_reg;
        idx_next        = idx_reg;
        unique case (state_reg)
            slt_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_byte_next = s_tdata;
                    last_next    = s_tlast;
                    state_next   = slt_pkg::ST_START_A;
                end
            end
            slt_pkg::ST_START_A:
            begin
                a_live_next = !drain_reg;
                used_next   = 1'b0;
                if (!drain_reg && held_valid_reg && !skip_reg)
                begin
                    cur_next   = held_reg;
                    la_ok_next = 1'b1;
                    phase_next = slt_pkg::PH_A;
                    state_next = slt_pkg::ST_DECODE;
                end
                else
                begin
                    state_next = slt_pkg::ST_AFTER_A;
                end
            end
            slt_pkg::ST_AFTER_A:
            begin
                if (a_live_reg)
                begin
                    held_next       = in_byte_reg;
                    held_valid_next = 1'b1;
                    skip_next       = used_reg;
                end
                state_next = last_reg ? slt_pkg::ST_START_B : slt_pkg::ST_IDLE;
            end
            slt_pkg::ST_START_B:
            begin
                if (!drain_reg && !skip_reg)
                begin
                    cur_next   = in_byte_reg;
                    la_ok_next = 1'b0;
                    phase_next = slt_pkg::PH_B;
                    state_next = slt_pkg::ST_DECODE;
                end
                else
                begin
                    state_next = slt_pkg::ST_FIN;
                end
            end
            slt_pkg::ST_DECODE:
            begin
                act_next  = act;
                used_next = act.used;
                idx_next  = '0;
                if (act.finish && mode_emits)
                begin
                    state_next = slt_pkg::ST_FL_RD;
                end
                else
                begin
                    if (act.finish)
                    begin
                        mode_next = slt_pkg::M_WS;
                        len_next  = '0;
                        ovf_next  = 1'b0;
                    end
                    state_next = slt_pkg::ST_POST;
                end
            end
            slt_pkg::ST_FIN:
            begin
                idx_next = '0;
                if (!drain_reg && mode_emits)
                begin
                    phase_next = slt_pkg::PH_FIN;
                    state_next = slt_pkg::ST_FL_RD;
                end
                else
                begin
                    state_next = slt_pkg::ST_END;
                end
            end
            slt_pkg::ST_FL_RD:
            begin
                state_next = (len_reg == '0) ? slt_pkg::ST_FL_EMPTY : slt_pkg::ST_FL_EMIT;
            end
            slt_pkg::ST_FL_EMIT:
            begin
                if (out_free)
                begin
                    if (flush_last)
                    begin
                        mode_next  = slt_pkg::M_WS;
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = flush_ret;
                    end
                    else
                    begin
                        idx_next   = idx_reg + slt_pkg::ADDR_W'(1);
                        state_next = slt_pkg::ST_FL_RD;
                    end
                end
            end
            slt_pkg::ST_FL_EMPTY:
            begin
                if (out_free)
                begin
                    mode_next  = slt_pkg::M_WS;
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = flush_ret;
                end
            end
            slt_pkg::ST_POST:
            begin
                if (act_reg.set_mode)
                begin
                    mode_next = act_reg.new_mode;
                end
                if (act_reg.append)
                begin
                    if (len_reg < slt_pkg::TOK_MAX_LEN)
                    begin
                        len_next = len_reg + slt_pkg::LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                if (act_reg.cmt_clear)
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
                if (act_reg.line_inc && line_reg != slt_pkg::LINE_MAX)
                begin
                    line_next = line_reg + slt_pkg::LINE_BITS'(1);
                end
                if (act_reg.op_cnt != 2'd0)
                begin
                    state_next = slt_pkg::ST_OP1;
                end
                else if (act_reg.err)
                begin
                    state_next = slt_pkg::ST_ERR;
                end
                else
                begin
                    state_next = lex_ret;
                end
            end
            slt_pkg::ST_OP1:
            begin
                if (out_free)
                begin
                    state_next = (act_reg.op_cnt == 2'd2) ? slt_pkg::ST_OP2 : lex_ret;
                end
            end
            slt_pkg::ST_OP2:
            begin
                if (out_free)
                begin
                    state_next = lex_ret;
                end
            end
            slt_pkg::ST_ERR:
            begin
                if (out_free)
                begin
                    drain_next = 1'b1;
                    state_next = lex_ret;
                end
            end
            slt_pkg::ST_END:
            begin
                if (out_free)
                begin
                    held_next       = 8'h00;
                    held_valid_next = 1'b0;
                    skip_next       = 1'b0;
                    mode_next       = slt_pkg::M_WS;
                    len_next        = '0;
                    ovf_next        = 1'b0;
                    line_next       = slt_pkg::LINE_FIRST;
                    drain_next      = 1'b0;
                    state_next      = slt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= slt_pkg::ST_IDLE;
            phase_reg      <= slt_pkg::PH_A;
            mode_reg       <= slt_pkg::M_WS;
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
            skip_reg       <= 1'b0;
            used_reg       <= 1'b0;
            a_live_reg     <= 1'b0;
            last_reg       <= 1'b0;
            la_ok_reg      <= 1'b0;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            line_reg       <= slt_pkg::LINE_FIRST;
            drain_reg      <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            mode_reg       <= mode_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            skip_reg       <= skip_next;
            used_reg       <= used_next;
            a_live_reg     <= a_live_next;
            last_reg       <= last_next;
            la_ok_reg      <= la_ok_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            line_reg       <= line_next;
            drain_reg      <= drain_next;
            idx_reg        <= idx_next;
            if (emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        in_byte_reg <= in_byte_next;
        cur_reg     <= cur_next;
        if (emit && out_free)
        begin
            out_kind_reg  <= e_kind;
            out_char_reg  <= e_char;
            out_cv_reg    <= e_cv;
            out_line_reg  <= line_out;
            out_done_reg  <= e_done;
            out_trunc_reg <= e_trunc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_trunc_reg, out_line_reg, out_cv_reg, out_char_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_done_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= slt_pkg::TOK_MAX_LEN)
        else $error("Token length exceeds the text buffer.");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == slt_pkg::ST_FL_EMIT |-> len_reg != '0)
        else $error("Replay of an empty token buffer.");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == slt_pkg::ST_END && out_free)
        |=> (line_reg == slt_pkg::LINE_FIRST && !drain_reg && !held_valid_reg))
        else $error("End record did not restore the initial state.");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == slt_pkg::ST_POST && len_reg < slt_pkg::TOK_MAX_LEN))
        else $error("Text buffer written outside an append.");

endmodule
